### sv/fcpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpq_pkg
// Shared types and constants of the four-class priority queue.
// ----------------------------------------------------------------------------
package fcpq_pkg;

	localparam int NUM_CLASSES     = 4;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int MIN_PER_HOUR    = 60;
	localparam int STAMP_W         = 11;
	localparam int WAIT_W          = 12;
	localparam int CNT_OUT_W       = 16;
	localparam int OCC_OUT_W       = 7;
	localparam int LEN_OUT_W       = 5;

	typedef enum logic {
		REQ_REGISTER = 1'b0,
		REQ_SERVE    = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_SERVED     = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_DROPPED    = 3'd3,
		ST_IGNORED    = 3'd4
	} status_t;

	typedef struct packed {
		logic       req_type;
		logic [2:0] patient_class;
		logic [4:0] event_hour;
		logic [5:0] event_minute;
	} fcpq_req_t;

	typedef struct packed {
		status_t                     status;
		logic [1:0]                  served_class;
		logic signed [WAIT_W-1:0]    wait_minutes;
		logic [STAMP_W-1:0]          max_wait;
		logic [CNT_OUT_W-1:0]        total_served;
		logic [CNT_OUT_W-1:0]        served_red;
		logic [CNT_OUT_W-1:0]        served_yellow;
		logic [CNT_OUT_W-1:0]        served_green;
		logic [CNT_OUT_W-1:0]        served_white;
		logic [OCC_OUT_W-1:0]        peak_occupancy;
		logic [OCC_OUT_W-1:0]        occupancy_total;
		logic [LEN_OUT_W-1:0]        class_length;
	} fcpq_rsp_t;

	// Snapshot of the queue state after one transaction, carried to the wait stage
	typedef struct packed {
		status_t               status;
		logic [1:0]            served_class;
		logic [STAMP_W-1:0]    stamp;
		logic [CNT_OUT_W-1:0]  total_served;
		logic [CNT_OUT_W-1:0]  served_red;
		logic [CNT_OUT_W-1:0]  served_yellow;
		logic [CNT_OUT_W-1:0]  served_green;
		logic [CNT_OUT_W-1:0]  served_white;
		logic [OCC_OUT_W-1:0]  peak_occupancy;
		logic [OCC_OUT_W-1:0]  occupancy_total;
		logic [LEN_OUT_W-1:0]  class_length;
	} fcpq_snap_t;

endpackage

### sv/four_class_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_class_priority_queue
// Strict-priority scheduler over four FIFO queues of arrival times.
// ----------------------------------------------------------------------------
// One request transaction is taken per clock cycle while req_stall is low,
// and every request yields exactly one result transaction: the bookkeeping
// stage does the queue bookkeeping and starts the read of the arrival store,
// whose read data is registered; the wait stage computes the wait and the
// running maximum wait; the result then sits in the output register. While
// a result waits to be taken, new input is taken only while the wait stage
// is empty. Red is served before yellow, green and white. The arrival store
// needs no clearing after reset, so the block is ready at once.
// ----------------------------------------------------------------------------
module four_class_priority_queue import fcpq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  fcpq_req_t req_data,
	output logic      res_valid,
	input  logic      res_stall,
	output fcpq_rsp_t res_data
);

	localparam int AW = $clog2(QUEUE_DEPTH) + 2;

	logic               accept;
	logic               s1_valid_s1;
	fcpq_snap_t         snap;
	fcpq_snap_t         snap_s1;
	logic               s1_advance;
	logic               s1_free;
	logic               s2_free;
	fcpq_rsp_t          rsp;
	logic               res_valid_q;
	fcpq_rsp_t          res_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [STAMP_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [STAMP_W-1:0] arrival_s1;

	// the output register frees up when empty or when its transaction is taken
	assign s2_free    = !res_valid_q || !res_stall;
	// advance the wait stage into the output register
	assign s1_advance = s1_valid_s1 && s2_free;
	assign s1_free    = !s1_valid_s1 || s2_free;
	assign req_stall  = !s1_free;
	assign accept     = req_valid && s1_free;

	fcpq_sched #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.snap   (snap)
	);

	// read data is loaded only on accept, so it holds with the stage-one snapshot
	fcpq_store #(
		.AW(AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(arrival_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_free) begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1 <= snap;
		end
	end

	fcpq_wait u_wait (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(s1_advance),
		.snap   (snap_s1),
		.arrival(arrival_s1),
		.rsp    (rsp)
	);

	// output register: hold while stalled, load when the wait stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_free) begin
			res_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			res_q <= rsp;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### sv/fcpq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpq_store
// Arrival time memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcpq_store import fcpq_pkg::*; #(
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [STAMP_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [STAMP_W-1:0] rd_data
);

	logic [STAMP_W-1:0] mem [0:(1 << AW)-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/fcpq_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpq_sched
// Queue bookkeeping at accept time: class pick, heads, lengths, counters.
// ----------------------------------------------------------------------------
module fcpq_sched import fcpq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	localparam int QW = $clog2(QUEUE_DEPTH),
	localparam int AW = QW + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  fcpq_req_t          req,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [STAMP_W-1:0] wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	output fcpq_snap_t         snap
);

	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = QW + 1;
	localparam int OW = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [QW-1:0]          head_q [NUM_CLASSES];
	logic [LW-1:0]          len_q  [NUM_CLASSES];
	logic [OW-1:0]          peak_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] per_q  [NUM_CLASSES];

	logic [QW-1:0]          head_n [NUM_CLASSES];
	logic [LW-1:0]          len_n  [NUM_CLASSES];
	logic [OW-1:0]          peak_n;
	logic [OW-1:0]          occ_n;
	logic [COUNT_WIDTH-1:0] total_n;
	logic [COUNT_WIDTH-1:0] per_n  [NUM_CLASSES];

	logic [1:0]         cls;
	logic [1:0]         pick;
	logic               any_waiting;
	logic               cls_known;
	logic               is_serve;
	logic               is_full;
	logic               push;
	logic               pop;
	logic [STAMP_W-1:0] stamp;
	logic [SW-1:0]      tail_sum;
	logic [QW-1:0]      tail;
	logic [SW-1:0]      head_sum;
	logic [QW-1:0]      head_next;

	assign cls       = req.patient_class[1:0];
	assign cls_known = (req.patient_class < 3'(NUM_CLASSES));
	assign is_serve  = (req.req_type == REQ_SERVE);
	assign stamp     = STAMP_W'(req.event_hour) * STAMP_W'(MIN_PER_HOUR)
		+ STAMP_W'(req.event_minute);

	// most urgent non-empty queue
	always_comb begin
		pick        = 2'd0;
		any_waiting = 1'b0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (len_q[c] != '0) begin
				pick        = 2'(c);
				any_waiting = 1'b1;
			end
		end
	end

	assign is_full  = (len_q[cls] >= LW'(QUEUE_DEPTH));
	assign push     = !is_serve && cls_known && !is_full;
	assign pop      = is_serve && any_waiting;

	assign tail_sum = SW'(head_q[cls]) + SW'(len_q[cls]);
	assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
		: QW'(tail_sum);
	assign head_sum  = SW'(head_q[pick]) + SW'(1);
	assign head_next = (head_sum >= SW'(QUEUE_DEPTH)) ? '0 : QW'(head_sum);

	always_comb begin
		head_n  = head_q;
		len_n   = len_q;
		per_n   = per_q;
		total_n = total_q;
		if (push) begin
			len_n[cls] = len_q[cls] + LW'(1);
		end
		if (pop) begin
			head_n[pick] = head_next;
			len_n[pick]  = len_q[pick] - LW'(1);
			per_n[pick]  = (per_q[pick] == CNT_MAX) ? CNT_MAX : per_q[pick] + 1'b1;
			total_n      = (total_q == CNT_MAX) ? CNT_MAX : total_q + 1'b1;
		end
		occ_n = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			occ_n = occ_n + OW'(len_n[c]);
		end
		// only a register transaction checks the peak
		peak_n = (!is_serve && occ_n > peak_q) ? occ_n : peak_q;
	end

	always_comb begin
		snap.status       = ST_REGISTERED;
		snap.served_class = 2'd0;
		snap.class_length = '0;
		if (is_serve) begin
			if (any_waiting) begin
				snap.status       = ST_SERVED;
				snap.served_class = pick;
				snap.class_length = LEN_OUT_W'(len_n[pick]);
			end else begin
				snap.status = ST_EMPTY;
			end
		end else if (!cls_known) begin
			snap.status = ST_IGNORED;
		end else begin
			snap.status       = is_full ? ST_DROPPED : ST_REGISTERED;
			snap.class_length = LEN_OUT_W'(len_n[cls]);
		end
		snap.stamp           = stamp;
		snap.total_served    = CNT_OUT_W'(total_n);
		snap.served_red      = CNT_OUT_W'(per_n[0]);
		snap.served_yellow   = CNT_OUT_W'(per_n[1]);
		snap.served_green    = CNT_OUT_W'(per_n[2]);
		snap.served_white    = CNT_OUT_W'(per_n[3]);
		snap.peak_occupancy  = OCC_OUT_W'(peak_n);
		snap.occupancy_total = OCC_OUT_W'(occ_n);
	end

	assign wr_en   = accept && push;
	assign wr_addr = {cls, tail};
	assign wr_data = stamp;
	assign rd_en   = accept && pop;
	assign rd_addr = {pick, head_q[pick]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				len_q[c]  <= '0;
				per_q[c]  <= '0;
			end
			peak_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			len_q   <= len_n;
			per_q   <= per_n;
			peak_q  <= peak_n;
			total_q <= total_n;
		end
	end

endmodule

### sv/fcpq_wait.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpq_wait
// Wait stage: wait minutes, running maximum wait, result assembly.
// ----------------------------------------------------------------------------
module fcpq_wait import fcpq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  fcpq_snap_t         snap,
	input  logic [STAMP_W-1:0] arrival,
	output fcpq_rsp_t          rsp
);

	logic [STAMP_W-1:0]       longest_q;
	logic [STAMP_W-1:0]       longest_n;
	logic signed [WAIT_W-1:0] wait_diff;
	logic                     served;
	logic                     raise;

	assign served    = (snap.status == ST_SERVED);
	assign wait_diff = $signed({1'b0, snap.stamp}) - $signed({1'b0, arrival});
	// negative or zero waits never raise the maximum
	assign raise     = served && !wait_diff[WAIT_W-1] && (wait_diff != '0)
		&& (wait_diff[STAMP_W-1:0] > longest_q);
	assign longest_n = raise ? wait_diff[STAMP_W-1:0] : longest_q;

	always_comb begin
		rsp.status          = snap.status;
		rsp.served_class    = snap.served_class;
		rsp.wait_minutes    = served ? wait_diff : '0;
		rsp.max_wait        = longest_n;
		rsp.total_served    = snap.total_served;
		rsp.served_red      = snap.served_red;
		rsp.served_yellow   = snap.served_yellow;
		rsp.served_green    = snap.served_green;
		rsp.served_white    = snap.served_white;
		rsp.peak_occupancy  = snap.peak_occupancy;
		rsp.occupancy_total = snap.occupancy_total;
		rsp.class_length    = snap.class_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			longest_q <= '0;
		end else if (advance) begin
			longest_q <= longest_n;
		end
	end

endmodule

### sim/four_class_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_class_priority_queue_test
// Self-checking testbench of the four-class strict-priority patient queue.
// ----------------------------------------------------------------------------
// A driver feeds register and serve transactions from a queue that is filled
// up front: a short directed list first, then random segments that fill,
// drain, flood one class or mix both kinds. Each accepted transaction runs
// through a behavioral copy of the four FIFOs and their counters, and the
// outcome it yields is queued. A monitor takes every result transaction and
// compares it field by field with the oldest queued outcome. Both sides idle
// in random bursts, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module four_class_priority_queue_test;
	import fcpq_pkg::*;

	localparam int QDEPTH       = DEF_QUEUE_DEPTH;
	localparam int COUNT_LIMIT  = (1 << DEF_COUNT_WIDTH) - 1;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_TAIL   = 150;       // no idling once this few are left
	localparam int HOLD_CYCLES  = 250;       // long receiver hold-off
	localparam int HOLD_AFTER   = 300;       // accepted transactions before it
	localparam int DRAIN_CYCLES = 12;        // idle cycles after the drain
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	fcpq_req_t req_data  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	fcpq_rsp_t res_data;

	four_class_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always #5 clk = ~clk;

	// Transactions waiting to be sent, and outcomes waiting to be observed
	fcpq_req_t patient_events[$];
	fcpq_rsp_t pending_outcomes[$];

	// Behavioral copy of the queue state
	logic [STAMP_W-1:0] arrival_time [NUM_CLASSES][QDEPTH];
	int oldest_slot     [NUM_CLASSES];
	int waiting         [NUM_CLASSES];
	int served_by_class [NUM_CLASSES];
	int peak_seen;
	int longest_seen;
	int served_all;

	int  accepted_count = 0;
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  send_gap       = 0;
	int  recv_gap       = 0;
	logic hold_off      = 1'b0;
	logic quiet_tail;

	assign quiet_tail = (patient_events.size() < QUIET_TAIL);

	initial begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			oldest_slot[c]     = 0;
			waiting[c]         = 0;
			served_by_class[c] = 0;
		end
		peak_seen    = 0;
		longest_seen = 0;
		served_all   = 0;
	end

	// Advance the queue copy by one transaction and return the result it causes
	function automatic fcpq_rsp_t queue_step_outcome(fcpq_req_t r);
		fcpq_rsp_t rsp;
		int stamp;
		int cls;
		int slot;
		int pick;
		int wait_val;
		int occ;
		rsp   = '0;
		stamp = int'(r.event_hour) * MIN_PER_HOUR + int'(r.event_minute);
		cls   = int'(r.patient_class);
		pick  = -1;
		if (r.req_type == REQ_REGISTER) begin
			if (cls >= NUM_CLASSES) begin
				rsp.status = ST_IGNORED;
			end else if (waiting[cls] >= QDEPTH) begin
				rsp.status       = ST_DROPPED;
				rsp.class_length = waiting[cls][LEN_OUT_W-1:0];
			end else begin
				slot = (oldest_slot[cls] + waiting[cls]) % QDEPTH;
				arrival_time[cls][slot] = stamp[STAMP_W-1:0];
				waiting[cls]++;
				rsp.status       = ST_REGISTERED;
				rsp.class_length = waiting[cls][LEN_OUT_W-1:0];
			end
			occ = waiting[0] + waiting[1] + waiting[2] + waiting[3];
			// the peak is checked even when nothing was queued
			if (occ > peak_seen)
				peak_seen = occ;
		end else begin
			for (int c = NUM_CLASSES - 1; c >= 0; c--)
				if (waiting[c] != 0)
					pick = c;
			if (pick < 0) begin
				rsp.status = ST_EMPTY;
			end else begin
				wait_val = stamp - int'(arrival_time[pick][oldest_slot[pick]]);
				oldest_slot[pick] = (oldest_slot[pick] + 1) % QDEPTH;
				waiting[pick]--;
				if (served_by_class[pick] < COUNT_LIMIT)
					served_by_class[pick]++;
				if (served_all < COUNT_LIMIT)
					served_all++;
				// a negative wait is reported but never raises the maximum
				if (wait_val > longest_seen)
					longest_seen = wait_val;
				rsp.status       = ST_SERVED;
				rsp.served_class = pick[1:0];
				rsp.wait_minutes = wait_val[WAIT_W-1:0];
				rsp.class_length = waiting[pick][LEN_OUT_W-1:0];
			end
			occ = waiting[0] + waiting[1] + waiting[2] + waiting[3];
		end
		rsp.max_wait        = longest_seen[STAMP_W-1:0];
		rsp.total_served    = served_all[CNT_OUT_W-1:0];
		rsp.served_red      = served_by_class[0][CNT_OUT_W-1:0];
		rsp.served_yellow   = served_by_class[1][CNT_OUT_W-1:0];
		rsp.served_green    = served_by_class[2][CNT_OUT_W-1:0];
		rsp.served_white    = served_by_class[3][CNT_OUT_W-1:0];
		rsp.peak_occupancy  = peak_seen[OCC_OUT_W-1:0];
		rsp.occupancy_total = occ[OCC_OUT_W-1:0];
		return rsp;
	endfunction

	task automatic queue_event(req_kind_t kind, int cls, int hour, int minute);
		fcpq_req_t r;
		r.req_type      = kind;
		r.patient_class = cls[2:0];
		r.event_hour    = hour[4:0];
		r.event_minute  = minute[5:0];
		patient_events.push_back(r);
	endtask

	// Random event; fixed_cls below zero picks a class, mostly a known one
	task automatic queue_random_event(int register_pct, int fixed_cls);
		int cls;
		int hour;
		int minute;
		if (fixed_cls >= 0)
			cls = fixed_cls;
		else if ($urandom_range(0, 9) == 0)
			cls = $urandom_range(4, 7);
		else
			cls = $urandom_range(0, 3);
		// now and then use the whole width of the time fields
		if ($urandom_range(0, 7) == 0) begin
			hour   = $urandom_range(0, 31);
			minute = $urandom_range(0, 63);
		end else begin
			hour   = $urandom_range(0, 23);
			minute = $urandom_range(0, 59);
		end
		queue_event(($urandom_range(0, 99) < register_pct) ? REQ_REGISTER : REQ_SERVE,
			cls, hour, minute);
	endtask

	task automatic note_field(string field, longint want, longint got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s at cycle %0d: expected %0d, got %0d",
					field, cycle_count, want, got);
		end
	endtask

	// Driver: offer the next transaction once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				pending_outcomes.push_back(queue_step_outcome(req_data));
				accepted_count++;
			end
			// hold the payload while stalled
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (patient_events.size() > 0) begin
					req_data  <= patient_events.pop_front();
					req_valid <= 1'b1;
					if (!quiet_tail && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction and drive the receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result at cycle %0d: status %0d",
							cycle_count, res_data.status);
				end else begin
					fcpq_rsp_t want;
					want = pending_outcomes.pop_front();
					note_field("status", want.status, res_data.status);
					note_field("served_class", want.served_class, res_data.served_class);
					note_field("wait_minutes", want.wait_minutes, res_data.wait_minutes);
					note_field("max_wait", want.max_wait, res_data.max_wait);
					note_field("total_served", want.total_served, res_data.total_served);
					note_field("served_red", want.served_red, res_data.served_red);
					note_field("served_yellow", want.served_yellow, res_data.served_yellow);
					note_field("served_green", want.served_green, res_data.served_green);
					note_field("served_white", want.served_white, res_data.served_white);
					note_field("peak_occupancy", want.peak_occupancy,
						res_data.peak_occupancy);
					note_field("occupancy_total", want.occupancy_total,
						res_data.occupancy_total);
					note_field("class_length", want.class_length, res_data.class_length);
				end
			end
			if (hold_off) begin
				res_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (!quiet_tail && $urandom_range(0, 7) == 0)
					recv_gap = $urandom_range(1, 19);
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering transactions
	initial begin
		while (accepted_count < HOLD_AFTER)
			@(negedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("four_class_priority_queue test failed");
			$finish;
		end
	end

	initial begin
		int total_items;
		int seg_len;
		int flood_cls;

		// Directed: empty serve, widest positive and negative waits, unknown classes,
		// strict priority across classes, class field ignored on serve, zero wait
		queue_event(REQ_SERVE, 0, 0, 0);
		queue_event(REQ_REGISTER, 0, 0, 0);
		queue_event(REQ_SERVE, 0, 31, 63);
		queue_event(REQ_REGISTER, 3, 31, 63);
		queue_event(REQ_SERVE, 0, 0, 0);
		for (int c = 4; c < 8; c++)
			queue_event(REQ_REGISTER, c, 23, 59);
		queue_event(REQ_REGISTER, 2, 12, 30);
		queue_event(REQ_REGISTER, 1, 12, 40);
		queue_event(REQ_REGISTER, 0, 12, 50);
		queue_event(REQ_SERVE, 7, 13, 0);
		queue_event(REQ_SERVE, 3, 13, 0);
		queue_event(REQ_SERVE, 0, 13, 0);
		queue_event(REQ_SERVE, 5, 13, 0);
		queue_event(REQ_REGISTER, 3, 20, 0);
		queue_event(REQ_SERVE, 0, 20, 0);

		// Random segments: mixed, filling, draining, and flooding one class to or past full
		total_items = patient_events.size() + RANDOM_ITEMS;
		while (patient_events.size() < total_items) begin
			case ($urandom_range(0, 3))
				0: begin
					seg_len = $urandom_range(10, 40);
					repeat (seg_len) queue_random_event(50, -1);
				end
				1: begin
					seg_len = $urandom_range(40, 90);
					repeat (seg_len) queue_random_event(85, -1);
				end
				2: begin
					seg_len = $urandom_range(20, 70);
					repeat (seg_len) queue_random_event(15, -1);
				end
				default: begin
					flood_cls = $urandom_range(0, 3);
					seg_len   = $urandom_range(16, 22);
					repeat (seg_len) queue_random_event(100, flood_cls);
					seg_len = $urandom_range(1, 6);
					repeat (seg_len) queue_random_event(0, -1);
				end
			endcase
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, taken and checked, then idle for DRAIN_CYCLES
		@(negedge clk);
		while (patient_events.size() != 0 || req_valid || pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (pending_outcomes.size() != 0)
			$display("%0d results never arrived", pending_outcomes.size());
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("four_class_priority_queue test passed");
		else
			$display("four_class_priority_queue test failed");
		$finish;
	end

endmodule
